@@ rtl/lkvc_pkg.sv @@
// shared types and codes for the lru key/value cache
package lkvc_pkg;

  localparam int KEY_W  = 64;
  localparam int IDATA_W = 32;
  localparam int OCC_W  = 5;

  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  typedef struct packed {
    logic               op;
    logic [KEY_W-1:0]   lookup_key;
    logic [IDATA_W-1:0] entry_data;
  } req_t;

  typedef struct packed {
    logic               hit;
    logic [IDATA_W-1:0] read_data;
    logic               evicted;
    logic [OCC_W-1:0]   occupancy;
  } rsp_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_CMP,
    BK_UPD
  } back_state_t;

  // front queue to engine link
  typedef struct packed {
    logic valid;
    req_t req;
  } queue_head_t;

endpackage

@@ rtl/lkvc_front.sv @@
// front end: accepts request transactions into a two-entry queue
module lkvc_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  lkvc_pkg::req_t            in_data,
  output lkvc_pkg::queue_head_t     head,
  input  logic                      pop
);
  import lkvc_pkg::*;

  req_t       q_mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;
  logic       push;

  assign in_stall   = (cnt_r == 2'd2);
  assign push       = in_valid && !in_stall;
  assign head.valid = (cnt_r != 2'd0);
  assign head.req   = q_mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

@@ rtl/lkvc_back.sv @@
// back end: tag compare, recency update and result register
module lkvc_back #(
  parameter int CAPACITY   = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  lkvc_pkg::queue_head_t head,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output lkvc_pkg::rsp_t        out_data
);
  import lkvc_pkg::*;

  localparam int RANK_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W  = $clog2(CAPACITY + 1);

  // entry storage, one lane per entry
  logic [CAPACITY-1:0]   valid_r;
  logic [KEY_W-1:0]      key_r   [CAPACITY];
  logic [DATA_WIDTH-1:0] data_r  [CAPACITY];
  logic [RANK_W-1:0]     rank_r  [CAPACITY];
  logic [CNT_W-1:0]      count_r;

  back_state_t state_r, state_nxt;
  req_t        req_r;

  // compare stage results
  logic [CAPACITY-1:0]   slot_r;
  logic                  hit_r;
  logic                  evict_r;
  logic [RANK_W-1:0]     hit_rank_r;
  logic [DATA_WIDTH-1:0] hit_data_r;

  logic [CAPACITY-1:0]   match_vec;
  logic [CAPACITY-1:0]   victim_vec;
  logic [CAPACITY-1:0]   free_oh;
  logic [RANK_W-1:0]     hit_rank;
  logic [DATA_WIDTH-1:0] hit_data;
  logic                  full;

  logic                  cmp_en;
  logic                  commit;
  logic                  out_free;
  logic                  is_put;
  logic [CNT_W-1:0]      count_nxt;

  rsp_t                  out_r;
  logic                  out_valid_r;

  assign full     = (count_r == CNT_W'(CAPACITY));
  assign out_free = !out_valid_r || !out_stall;
  assign is_put   = (req_r.op == OP_PUT);
  assign free_oh  = ~valid_r & (valid_r + CAPACITY'(1));

  always_comb begin
    hit_rank = '0;
    hit_data = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      match_vec[i]  = valid_r[i] && (key_r[i] == req_r.lookup_key);
      victim_vec[i] = valid_r[i] && (rank_r[i] == RANK_W'(CAPACITY - 1));
      hit_rank      = hit_rank | (rank_r[i] & {RANK_W{match_vec[i]}});
      hit_data      = hit_data | (data_r[i] & {DATA_WIDTH{match_vec[i]}});
    end
  end

  // sequencer: next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: if (head.valid) state_nxt = BK_CMP;
      BK_CMP:  state_nxt = BK_UPD;
      BK_UPD:  if (out_free) state_nxt = BK_IDLE;
      default: state_nxt = BK_IDLE;
    endcase
  end

  // sequencer: outputs
  always_comb begin
    pop    = 1'b0;
    cmp_en = 1'b0;
    commit = 1'b0;
    case (state_r)
      BK_IDLE: pop    = head.valid;
      BK_CMP:  cmp_en = 1'b1;
      BK_UPD:  commit = out_free;
      default: ;
    endcase
  end

  always_comb begin
    count_nxt = count_r;
    if (!hit_r && is_put && !evict_r) begin
      count_nxt = count_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      req_r <= head.req;
    end
    if (cmp_en) begin
      hit_r      <= |match_vec;
      evict_r    <= !(|match_vec) && (req_r.op == OP_PUT) && full;
      hit_rank_r <= hit_rank;
      hit_data_r <= hit_data;
      if (|match_vec) begin
        slot_r <= match_vec;
      end else if (full) begin
        slot_r <= victim_vec;
      end else begin
        slot_r <= free_oh;
      end
    end
  end

  // key and data lanes
  always_ff @(posedge clk) begin
    for (int i = 0; i < CAPACITY; i++) begin
      if (commit && is_put && slot_r[i]) begin
        data_r[i] <= DATA_WIDTH'(req_r.entry_data);
        if (!hit_r) begin
          key_r[i] <= req_r.lookup_key;
        end
      end
    end
  end

  // valid bits, recency ranks and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      count_r <= '0;
      for (int i = 0; i < CAPACITY; i++) begin
        rank_r[i] <= '0;
      end
    end else if (commit) begin
      count_r <= count_nxt;
      for (int i = 0; i < CAPACITY; i++) begin
        if (hit_r) begin
          if (slot_r[i]) begin
            rank_r[i] <= '0;
          end else if (valid_r[i] && (rank_r[i] < hit_rank_r)) begin
            rank_r[i] <= rank_r[i] + RANK_W'(1);
          end
        end else if (is_put) begin
          if (slot_r[i]) begin
            valid_r[i] <= 1'b1;
            rank_r[i]  <= '0;
          end else if (valid_r[i]) begin
            rank_r[i] <= rank_r[i] + RANK_W'(1);
          end
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (commit) begin
      out_r.hit       <= hit_r;
      out_r.read_data <= (hit_r && !is_put) ? IDATA_W'(hit_data_r) : '0;
      out_r.evicted   <= evict_r;
      out_r.occupancy <= OCC_W'(count_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (commit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

@@ rtl/lru_key_value_cache_top.sv @@
// top level of the fully associative lru key/value cache
//
//   channel | direction | handshake             | payload
//   in_     | input     | in_valid / in_stall   | lkvc_pkg::req_t (op, key, data)
//   out_    | output    | out_valid / out_stall | lkvc_pkg::rsp_t (hit, data, evict, occ)
//
// each transaction passes through three engine steps: take from queue, parallel key
// compare across all entries, then recency/data update with the result write.
// a two-entry queue lets requests arrive while the engine is busy.
// synchronous active-low reset empties the cache; no clearing pass is needed.
// a stalled result holds the engine in its update step; the queue keeps accepting
// until both of its entries are taken.
module lru_key_value_cache_top #(
  parameter int CAPACITY   = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  lkvc_pkg::req_t in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output lkvc_pkg::rsp_t out_data
);
  import lkvc_pkg::*;

  queue_head_t head;
  logic        pop;

  lkvc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .head     (head),
    .pop      (pop)
  );

  lkvc_back #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

@@ bench/lkvc_cache_checker.sv @@
// lru cache checker: tracks cache contents, predicts each response and compares it
module lkvc_cache_checker #(
  parameter int CAPACITY = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_stall,
  input  lkvc_pkg::req_t in_data,
  input  logic           out_valid,
  input  logic           out_stall,
  input  lkvc_pkg::rsp_t out_data,
  output int             mismatches,
  output int             outstanding,
  output int             results_seen,
  output int             hits_seen,
  output int             evictions_seen
);

  import lkvc_pkg::*;

  // shadow copy of the cache lines; age 0 is most recently used
  logic               line_vld [CAPACITY];
  logic [KEY_W-1:0]   line_key [CAPACITY];
  logic [IDATA_W-1:0] line_dat [CAPACITY];
  int unsigned        line_age [CAPACITY];
  int unsigned        line_cnt;

  rsp_t expected_rsp_q [$];

  function automatic rsp_t cache_access(req_t r);
    rsp_t        res;
    int          slot;
    bit          found;
    bit          placed;
    int unsigned old_age;
    int unsigned worst;
    res   = '0;
    slot  = 0;
    found = 1'b0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (!found && line_vld[i] && line_key[i] == r.lookup_key) begin
        slot  = i;
        found = 1'b1;
      end
    end
    if (found) begin
      res.hit = 1'b1;
      if (r.op == OP_GET) begin
        res.read_data = line_dat[slot];
      end else begin
        line_dat[slot] = r.entry_data;
      end
      // only lines younger than the touched one get older
      old_age = line_age[slot];
      for (int i = 0; i < CAPACITY; i++) begin
        if (line_vld[i] && line_age[i] < old_age) line_age[i]++;
      end
      line_age[slot] = 0;
    end else if (r.op == OP_PUT) begin
      placed = 1'b0;
      if (line_cnt < CAPACITY) begin
        // lowest free slot
        for (int i = 0; i < CAPACITY; i++) begin
          if (!placed && !line_vld[i]) begin
            slot   = i;
            placed = 1'b1;
          end
        end
        line_cnt++;
      end else begin
        // full: replace the oldest line
        worst = 0;
        for (int i = 0; i < CAPACITY; i++) begin
          if (line_vld[i] && (!placed || line_age[i] > worst)) begin
            worst  = line_age[i];
            slot   = i;
            placed = 1'b1;
          end
        end
        res.evicted = 1'b1;
      end
      for (int i = 0; i < CAPACITY; i++) begin
        if (line_vld[i] && i != slot) line_age[i]++;
      end
      line_vld[slot] = 1'b1;
      line_key[slot] = r.lookup_key;
      line_dat[slot] = r.entry_data;
      line_age[slot] = 0;
    end
    res.occupancy = line_cnt[OCC_W-1:0];
    return res;
  endfunction

  task automatic check_field(string name, logic [IDATA_W-1:0] want, logic [IDATA_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : monitor
    rsp_t want;
    if (!rst_n) begin
      for (int i = 0; i < CAPACITY; i++) begin
        line_vld[i] = 1'b0;
        line_key[i] = '0;
        line_dat[i] = '0;
        line_age[i] = 0;
      end
      line_cnt = 0;
      expected_rsp_q.delete();
      mismatches     = 0;
      outstanding    = 0;
      results_seen   = 0;
      hits_seen      = 0;
      evictions_seen = 0;
    end else begin
      // a response can never belong to the request taken on the same edge
      if (out_valid && !out_stall) begin
        results_seen++;
        if (out_data.hit === 1'b1) hits_seen++;
        if (out_data.evicted === 1'b1) evictions_seen++;
        if (expected_rsp_q.size() == 0) begin
          $display("%0t: unexpected response 0x%0h, expected none", $time, out_data);
          mismatches++;
        end else begin
          want = expected_rsp_q.pop_front();
          check_field("hit", IDATA_W'(want.hit), IDATA_W'(out_data.hit));
          check_field("read_data", want.read_data, out_data.read_data);
          check_field("evicted", IDATA_W'(want.evicted), IDATA_W'(out_data.evicted));
          check_field("occupancy", IDATA_W'(want.occupancy), IDATA_W'(out_data.occupancy));
        end
      end
      if (in_valid && !in_stall) begin
        expected_rsp_q.insert(expected_rsp_q.size(), cache_access(in_data));
      end
      outstanding = expected_rsp_q.size();
    end
  end

endmodule

@@ bench/lru_key_value_cache_top_tb.sv @@
// testbench top for the lru key/value cache: stimulus, flow control and verdict
module lru_key_value_cache_top_tb;

  import lkvc_pkg::*;

  localparam int HOLD_CYCLES = 80;
  localparam int POOL_SIZE   = 24;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  req_t in_data;
  logic out_valid;
  logic out_stall;
  rsp_t out_data;

  int mismatches;
  int outstanding;
  int results_seen;
  int hits_seen;
  int evictions_seen;

  bit idle_on  = 1'b1;
  bit hold_req = 1'b0;

  logic [KEY_W-1:0] key_pool [POOL_SIZE];

  lru_key_value_cache_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  lkvc_cache_checker checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data       (out_data),
    .mismatches     (mismatches),
    .outstanding    (outstanding),
    .results_seen   (results_seen),
    .hits_seen      (hits_seen),
    .evictions_seen (evictions_seen)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #2400000;
    $display("Test completed with failures");
    $finish;
  end

  function automatic req_t mk_req(logic op, logic [KEY_W-1:0] k, logic [IDATA_W-1:0] d);
    req_t r;
    r.op         = op;
    r.lookup_key = k;
    r.entry_data = d;
    return r;
  endfunction

  // mostly keys from the first span entries of the pool, now and then a stray key
  function automatic req_t rand_req(int span);
    req_t r;
    r.op = $urandom_range(0, 1) ? OP_PUT : OP_GET;
    if ($urandom_range(0, 9) == 0) r.lookup_key = {$urandom, $urandom};
    else r.lookup_key = key_pool[$urandom_range(0, span - 1)];
    case ($urandom_range(0, 15))
      0:       r.entry_data = '0;
      1:       r.entry_data = '1;
      default: r.entry_data = $urandom;
    endcase
    return r;
  endfunction

  // entered and left at a falling edge; valid stays high into the next transaction
  task automatic push_req(req_t r);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic run_phase(int count, int span);
    for (int n = 0; n < count; n++) push_req(rand_req(span));
  endtask

  // response side: random stall bursts plus one long hold-off on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_stall <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 7)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    int k;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (k = 2; k < POOL_SIZE; k++) key_pool[k] = {$urandom, $urandom};
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // corner cases: extreme keys and data, update in place, fill, evict, full-cache hits
    push_req(mk_req(OP_PUT, '0, '1));
    push_req(mk_req(OP_GET, '0, 32'h1234_5678));
    push_req(mk_req(OP_PUT, '1, '0));
    push_req(mk_req(OP_GET, '1, '1));
    push_req(mk_req(OP_GET, 64'h0123_4567_89ab_cdef, '0));
    push_req(mk_req(OP_PUT, '0, 32'h5a5a_a5a5));
    push_req(mk_req(OP_GET, '0, '0));
    for (k = 1; k <= 14; k++) push_req(mk_req(OP_PUT, 64'(k), $urandom));
    // all-ones key is now the oldest line
    push_req(mk_req(OP_PUT, 64'hdead_beef_0000_0001, 32'h0bad_cafe));
    push_req(mk_req(OP_GET, '1, '0));
    push_req(mk_req(OP_PUT, 64'd2, '1));
    push_req(mk_req(OP_GET, 64'd1, '0));

    // working set that fits
    run_phase(150, 12);

    // let everything drain before the thrashing phase
    in_valid <= 1'b0;
    wait (outstanding == 0);
    @(negedge clk);

    // working set bigger than the cache, starting under a long output hold-off
    hold_req = 1'b1;
    run_phase(150, POOL_SIZE);
    run_phase(100, 20);

    // back-to-back traffic, no idling on either side
    idle_on = 1'b0;
    run_phase(75, POOL_SIZE);

    in_valid <= 1'b0;
    wait (outstanding == 0);
    repeat (20) @(negedge clk);

    $display("checked %0d transactions: %0d hits, %0d evictions", results_seen, hits_seen,
             evictions_seen);
    $display("covered corner keys and data, resident and thrashing key sets, a %0d-cycle %s",
             HOLD_CYCLES, "output hold-off and a full drain pause");
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ lru_key_value_cache_top.f @@
rtl/lkvc_pkg.sv
rtl/lkvc_front.sv
rtl/lkvc_back.sv
rtl/lru_key_value_cache_top.sv
bench/lkvc_cache_checker.sv
bench/lru_key_value_cache_top_tb.sv
